// ----- rtl/core/bbmm_pkg.sv -----
// Shared constants and types of the batched block matrix multiplier.
`default_nettype none

package bbmm_pkg;

  // Batch geometry
  localparam int TILE_ROWS   = 4;
  localparam int TILE_COLS   = 4;
  localparam int INNER_LEN   = 8;
  localparam int PIPE_COUNT  = 2;
  localparam int DEPTH_COUNT = 2;

  localparam int TILE_PAIRS  = DEPTH_COUNT * PIPE_COUNT;
  localparam int A_TILE_SIZE = TILE_ROWS * INNER_LEN;
  localparam int B_TILE_SIZE = INNER_LEN * TILE_COLS;
  localparam int T_TILE_SIZE = TILE_ROWS * TILE_COLS;
  localparam int A_SIZE      = TILE_PAIRS * A_TILE_SIZE;
  localparam int B_SIZE      = TILE_PAIRS * B_TILE_SIZE;

  localparam int A_AW = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
  localparam int B_AW = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;

  // Sequencer counter widths
  localparam int KW = (INNER_LEN > 1) ? $clog2(INNER_LEN) : 1;
  localparam int RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int PW = (TILE_PAIRS > 1) ? $clog2(TILE_PAIRS) : 1;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 40;
  localparam int OIDX_W  = 6;

  localparam int IN_TDATA_W  = 24;  // index + value, padded to bytes
  localparam int OUT_TDATA_W = 48;  // product + out_index, padded to bytes

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Tag that rides along with each operand pair through the MAC
  typedef struct packed {
    logic              first_k;
    logic              last_k;
    logic              last_elem;
    logic [OIDX_W-1:0] oidx;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/bbmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bbmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/bbmm_mac.sv -----
// Shared multiply-accumulate unit: registered 16x16 product, 40-bit accumulator.
`default_nettype none

module bbmm_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic                                 op_valid,
  input  wire logic signed [bbmm_pkg::VAL_W-1:0]    op_a,
  input  wire logic signed [bbmm_pkg::VAL_W-1:0]    op_b,
  input  wire bbmm_pkg::tag_t                       op_tag,
  output logic                                      busy,
  output logic                                      res_valid,
  output logic signed [bbmm_pkg::SUM_W-1:0]         res_sum,
  output bbmm_pkg::tag_t                            res_tag
);

  import bbmm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  tag_t                     tag_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (en) begin
      prod_v_r <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
      tag_r  <= op_tag;
    end
    if (en && prod_v_r) begin
      acc_r <= res_sum;
    end
  end

  // Restart the running sum on the first inner step of each element
  assign acc_base  = tag_r.first_k ? '0 : acc_r;
  assign res_sum   = acc_base + SUM_W'(prod_r);
  assign res_valid = prod_v_r && tag_r.last_k;
  assign res_tag   = tag_r;
  assign busy      = prod_v_r;

endmodule

`default_nettype wire

// ----- rtl/core/batched_block_matrix_multiply.sv -----
// Top level of the batched block matrix multiplier: sequencer, tile stores, output register.
//
// Input channel (in_*): one beat per request. in_tuser carries the request kind:
// load A element, load B element, or start. A load beat writes its Q8.8 value into
// the A or B tile store at the flat index; loads are taken one per cycle while idle and give
// no result. Loads whose index lies beyond the batch and the unused kind are dropped.
// A start beat multiplies every tile pair and streams out one beat per product
// element, in flat order (depth, pipe, row, column), with out_tlast on the final one.
// Throughput: one shared MAC does one inner step per cycle unless the receiver stalls, so a
// start beat keeps the block busy through every inner step of every product element, then
// through the read, multiply and drain; in_tready is low for that whole run.
// When the receiver stalls with a result held in the output register, the whole
// read/multiply/accumulate pipe freezes until the beat is taken; nothing is lost.
// Reset (synchronous, active low) returns the sequencer to idle and clears all valid
// flags. Tile store contents are not cleared; read only entries that were loaded.
`default_nettype none

module batched_block_matrix_multiply (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Request channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [bbmm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [6:0] index, [22:7] value
  input  wire logic [bbmm_pkg::REQ_W-1:0]          in_tuser,   // [1:0] req_type
  // Result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [bbmm_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [39:0] product, [45:40] out_index
  output logic                                     out_tlast
);

  import bbmm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // ------------------------------------------------------------------
  // Request decode
  // ------------------------------------------------------------------
  logic              in_fire;
  logic [IDX_W-1:0]  req_idx;
  logic [VAL_W-1:0]  req_val;
  logic              a_we;
  logic              b_we;
  logic              start;

  assign in_fire = in_tvalid && in_tready;
  assign req_idx = in_tdata[IDX_W-1:0];
  assign req_val = in_tdata[IDX_W +: VAL_W];

  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    start = 1'b0;
    unique case (in_tuser)
      REQ_LOAD_A: a_we  = in_fire && (32'(req_idx) < A_SIZE);
      REQ_LOAD_B: b_we  = in_fire && (32'(req_idx) < B_SIZE);
      REQ_START:  start = in_fire;
      default:    start = 1'b0;  // unused kind: drop
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: walks pair, row, column, inner step
  // ------------------------------------------------------------------
  logic [1:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [RW-1:0] i_r, i_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic          adv;
  logic          issue;
  logic          k_end, j_end, i_end, p_end;
  logic          v1_r;
  tag_t          issue_tag;
  tag_t          tag1_r;
  logic          mac_busy;

  // Freeze the pipe while a result waits in the output register
  assign adv   = !out_tvalid || out_tready;
  assign issue = (state_r == ST_RUN) && adv;

  assign k_end = (k_r == KW'(INNER_LEN - 1));
  assign j_end = (j_r == CW'(TILE_COLS - 1));
  assign i_end = (i_r == RW'(TILE_ROWS - 1));
  assign p_end = (p_r == PW'(TILE_PAIRS - 1));

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          k_nxt = k_end ? '0 : k_r + 1'b1;
          if (k_end) begin
            j_nxt = j_end ? '0 : j_r + 1'b1;
            if (j_end) begin
              i_nxt = i_end ? '0 : i_r + 1'b1;
              if (i_end) begin
                p_nxt = p_end ? '0 : p_r + 1'b1;
                if (p_end) begin
                  state_nxt = ST_DRAIN;
                end
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        // Wait until the last operand pair has left the MAC
        if (!v1_r && !mac_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      p_r     <= p_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // ------------------------------------------------------------------
  // Tile stores and operand fetch
  // ------------------------------------------------------------------
  logic [A_AW-1:0]  a_raddr;
  logic [B_AW-1:0]  b_raddr;
  logic [VAL_W-1:0] a_rdata;
  logic [VAL_W-1:0] b_rdata;

  assign a_raddr = A_AW'(p_r * A_TILE_SIZE + i_r * INNER_LEN + k_r);
  assign b_raddr = B_AW'(p_r * B_TILE_SIZE + k_r * TILE_COLS + j_r);

  assign issue_tag.first_k   = (k_r == '0);
  assign issue_tag.last_k    = k_end;
  assign issue_tag.last_elem = p_end && i_end && j_end;
  assign issue_tag.oidx      = OIDX_W'(p_r * T_TILE_SIZE + i_r * TILE_COLS + j_r);

  bbmm_ram #(.WIDTH(VAL_W), .DEPTH(A_SIZE)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (A_AW'(req_idx)),
    .wdata (req_val),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bbmm_ram #(.WIDTH(VAL_W), .DEPTH(B_SIZE)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (B_AW'(req_idx)),
    .wdata (req_val),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Tag travels alongside the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= issue_tag;
    end
  end

  // ------------------------------------------------------------------
  // Shared MAC
  // ------------------------------------------------------------------
  logic                    res_valid;
  logic signed [SUM_W-1:0] res_sum;
  tag_t                    res_tag;

  bbmm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .op_valid  (v1_r),
    .op_a      (a_rdata),
    .op_b      (b_rdata),
    .op_tag    (tag1_r),
    .busy      (mac_busy),
    .res_valid (res_valid),
    .res_sum   (res_sum),
    .res_tag   (res_tag)
  );

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r;
  logic [OIDX_W-1:0] out_idx_r;
  logic              out_last_r;

  assign out_valid_nxt = adv ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_sum_r  <= res_sum;
      out_idx_r  <= res_tag.oidx;
      out_last_r <= res_tag.last_elem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - SUM_W - OIDX_W){1'b0}}, out_idx_r, out_sum_r};
  assign out_tlast  = out_last_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // Never take a request while operands are still in flight
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!v1_r && !mac_busy))
    else $error("request accepted with MAC pipe not empty");

  // Hold the inner-step counter while the receiver stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !adv) |=> $stable(k_r))
    else $error("sequencer advanced during output stall");

  // Operands only enter the pipe from the run state
  a_issue_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v1_r) |-> $past(state_r == ST_RUN))
    else $error("operand fetch outside run state");

  // The pipe is empty while the final result of a run waits to leave
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (!v1_r && !mac_busy))
    else $error("last result while operands still in flight");

endmodule

`default_nettype wire
